/* rtl/urba_pkg.sv */
// Package for the Unicode range bit accumulator.
// It holds the range table as a classify function and shared widths.
// It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package urba_pkg;

    localparam int CpWidth   = 21;
    localparam int MaskWidth = 123;
    localparam int IdxWidth  = 16;

    localparam logic [CpWidth-1:0] LeastReset = 21'h00FFFF;
    localparam logic [CpWidth-1:0] PlaneTwo   = 21'h010000;

    typedef struct packed {
        logic [MaskWidth-1:0] bits;
        logic [CpWidth-1:0]   cp;
        logic                 last;
    } class_item_t;

    function automatic logic in_span(input logic [CpWidth-1:0] cp,
                                     input logic [CpWidth-1:0] lo,
                                     input logic [CpWidth-1:0] hi);
        in_span = (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic [MaskWidth-1:0] classify(input logic [CpWidth-1:0] cp);
        logic [MaskWidth-1:0] m;
        m = '0;
        m[0]   = in_span(cp, 21'h0000, 21'h007F);
        m[1]   = in_span(cp, 21'h0080, 21'h00FF);
        m[2]   = in_span(cp, 21'h0100, 21'h017F);
        m[3]   = in_span(cp, 21'h0180, 21'h024F);
        m[4]   = in_span(cp, 21'h0250, 21'h02AF) | in_span(cp, 21'h1D00, 21'h1DBF);
        m[5]   = in_span(cp, 21'h02B0, 21'h02FF) | in_span(cp, 21'hA700, 21'hA71F);
        m[6]   = in_span(cp, 21'h0300, 21'h036F) | in_span(cp, 21'h1DC0, 21'h1DFF);
        m[7]   = in_span(cp, 21'h0370, 21'h03FF);
        m[8]   = in_span(cp, 21'h2C80, 21'h2CFF);
        m[9]   = in_span(cp, 21'h0400, 21'h052F) | in_span(cp, 21'h2DE0, 21'h2DFF)
               | in_span(cp, 21'hA640, 21'hA69F);
        m[10]  = in_span(cp, 21'h0530, 21'h058F);
        m[11]  = in_span(cp, 21'h0590, 21'h05FF);
        m[12]  = in_span(cp, 21'hA500, 21'hA63F);
        m[13]  = in_span(cp, 21'h0600, 21'h06FF) | in_span(cp, 21'h0750, 21'h077F);
        m[14]  = in_span(cp, 21'h07C0, 21'h07FF);
        m[15]  = in_span(cp, 21'h0900, 21'h097F);
        m[16]  = in_span(cp, 21'h0980, 21'h09FF);
        m[17]  = in_span(cp, 21'h0A00, 21'h0A7F);
        m[18]  = in_span(cp, 21'h0A80, 21'h0AFF);
        m[19]  = in_span(cp, 21'h0B00, 21'h0B7F);
        m[20]  = in_span(cp, 21'h0B80, 21'h0BFF);
        m[21]  = in_span(cp, 21'h0C00, 21'h0C7F);
        m[22]  = in_span(cp, 21'h0C80, 21'h0CFF);
        m[23]  = in_span(cp, 21'h0D00, 21'h0D7F);
        m[24]  = in_span(cp, 21'h0E00, 21'h0E7F);
        m[25]  = in_span(cp, 21'h0E80, 21'h0EFF);
        m[26]  = in_span(cp, 21'h10A0, 21'h10FF) | in_span(cp, 21'h2D00, 21'h2D2F);
        m[27]  = in_span(cp, 21'h1B00, 21'h1B7F);
        m[28]  = in_span(cp, 21'h1100, 21'h11FF);
        m[29]  = in_span(cp, 21'h1E00, 21'h1EFF) | in_span(cp, 21'h2C60, 21'h2C7F)
               | in_span(cp, 21'hA720, 21'hA7FF);
        m[30]  = in_span(cp, 21'h1F00, 21'h1FFF);
        m[31]  = in_span(cp, 21'h2000, 21'h206F) | in_span(cp, 21'h2E00, 21'h2E7F);
        m[32]  = in_span(cp, 21'h2070, 21'h209F);
        m[33]  = in_span(cp, 21'h20A0, 21'h20CF);
        m[34]  = in_span(cp, 21'h20D0, 21'h20FF);
        m[35]  = in_span(cp, 21'h2100, 21'h214F);
        m[36]  = in_span(cp, 21'h2150, 21'h218F);
        m[37]  = in_span(cp, 21'h2190, 21'h21FF) | in_span(cp, 21'h27F0, 21'h27FF)
               | in_span(cp, 21'h2900, 21'h297F) | in_span(cp, 21'h2B00, 21'h2BFF);
        m[38]  = in_span(cp, 21'h2200, 21'h22FF) | in_span(cp, 21'h2A00, 21'h2AFF)
               | in_span(cp, 21'h27C0, 21'h27EF) | in_span(cp, 21'h2980, 21'h29FF);
        m[39]  = in_span(cp, 21'h2300, 21'h23FF);
        m[40]  = in_span(cp, 21'h2400, 21'h243F);
        m[41]  = in_span(cp, 21'h2440, 21'h245F);
        m[42]  = in_span(cp, 21'h2460, 21'h24FF);
        m[43]  = in_span(cp, 21'h2500, 21'h257F);
        m[44]  = in_span(cp, 21'h2580, 21'h259F);
        m[45]  = in_span(cp, 21'h25A0, 21'h25FF);
        m[46]  = in_span(cp, 21'h2600, 21'h26FF);
        m[47]  = in_span(cp, 21'h2700, 21'h27BF);
        m[48]  = in_span(cp, 21'h3000, 21'h303F);
        m[49]  = in_span(cp, 21'h3040, 21'h309F);
        m[50]  = in_span(cp, 21'h30A0, 21'h30FF) | in_span(cp, 21'h31F0, 21'h31FF);
        m[51]  = in_span(cp, 21'h3100, 21'h312F) | in_span(cp, 21'h31A0, 21'h31BF);
        m[52]  = in_span(cp, 21'h3130, 21'h318F);
        m[53]  = in_span(cp, 21'hA840, 21'hA87F);
        m[54]  = in_span(cp, 21'h3200, 21'h32FF);
        m[55]  = in_span(cp, 21'h3300, 21'h33FF);
        m[56]  = in_span(cp, 21'hAC00, 21'hD7AF);
        m[57]  = in_span(cp, 21'hD800, 21'hDFFF) | (cp >= PlaneTwo);
        m[58]  = in_span(cp, 21'h10900, 21'h1091F);
        m[59]  = in_span(cp, 21'h4E00, 21'h9FFF) | in_span(cp, 21'h2E80, 21'h2EFF)
               | in_span(cp, 21'h2F00, 21'h2FDF) | in_span(cp, 21'h2FF0, 21'h2FFF)
               | in_span(cp, 21'h3400, 21'h4DBF) | in_span(cp, 21'h20000, 21'h2F7FF)
               | in_span(cp, 21'h3190, 21'h319F);
        m[60]  = in_span(cp, 21'hE000, 21'hF8FF);
        m[61]  = in_span(cp, 21'h31C0, 21'h31EF) | in_span(cp, 21'hF900, 21'hFAFF)
               | in_span(cp, 21'h2F800, 21'h2FA1F);
        m[62]  = in_span(cp, 21'hFB00, 21'hFB4F);
        m[63]  = in_span(cp, 21'hFB50, 21'hFDFF);
        m[64]  = in_span(cp, 21'hFE20, 21'hFE2F);
        m[65]  = in_span(cp, 21'hFE10, 21'hFE1F) | in_span(cp, 21'hFE30, 21'hFE4F);
        m[66]  = in_span(cp, 21'hFE50, 21'hFE6F);
        m[67]  = in_span(cp, 21'hFE70, 21'hFEFF);
        m[68]  = in_span(cp, 21'hFF00, 21'hFFEF);
        m[69]  = in_span(cp, 21'hFFF0, 21'hFFFF);
        m[70]  = in_span(cp, 21'h0F00, 21'h0FFF);
        m[71]  = in_span(cp, 21'h0700, 21'h074F);
        m[72]  = in_span(cp, 21'h0780, 21'h07BF);
        m[73]  = in_span(cp, 21'h0D80, 21'h0DFF);
        m[74]  = in_span(cp, 21'h1000, 21'h109F);
        m[75]  = in_span(cp, 21'h1200, 21'h139F) | in_span(cp, 21'h2D80, 21'h2DDF);
        m[76]  = in_span(cp, 21'h13A0, 21'h13FF);
        m[77]  = in_span(cp, 21'h1400, 21'h167F);
        m[78]  = in_span(cp, 21'h1680, 21'h169F);
        m[79]  = in_span(cp, 21'h16A0, 21'h16FF);
        m[80]  = in_span(cp, 21'h1780, 21'h17FF) | in_span(cp, 21'h19E0, 21'h19FF);
        m[81]  = in_span(cp, 21'h1800, 21'h18AF);
        m[82]  = in_span(cp, 21'h2800, 21'h28FF);
        m[83]  = in_span(cp, 21'hA000, 21'hA4CF);
        m[84]  = in_span(cp, 21'h1700, 21'h177F);
        m[85]  = in_span(cp, 21'h10300, 21'h1032F);
        m[86]  = in_span(cp, 21'h10330, 21'h1034F);
        m[87]  = in_span(cp, 21'h10400, 21'h1044F);
        m[88]  = in_span(cp, 21'h1D000, 21'h1D24F);
        m[89]  = in_span(cp, 21'h1D400, 21'h1D7FF);
        m[90]  = in_span(cp, 21'hFF000, 21'hFFFFD) | in_span(cp, 21'h100000, 21'h10FFFD);
        m[91]  = in_span(cp, 21'hFE00, 21'hFE0F) | in_span(cp, 21'hE0100, 21'hE01EF);
        m[92]  = in_span(cp, 21'hE0000, 21'hE007F);
        m[93]  = in_span(cp, 21'h1900, 21'h194F);
        m[94]  = in_span(cp, 21'h1950, 21'h197F);
        m[95]  = in_span(cp, 21'h1980, 21'h19DF);
        m[96]  = in_span(cp, 21'h1A00, 21'h1A1F);
        m[97]  = in_span(cp, 21'h2C00, 21'h2C5F);
        m[98]  = in_span(cp, 21'h2D30, 21'h2D7F);
        m[99]  = in_span(cp, 21'h4DC0, 21'h4DFF);
        m[100] = in_span(cp, 21'hA800, 21'hA82F);
        m[101] = in_span(cp, 21'h10000, 21'h1013F);
        m[102] = in_span(cp, 21'h10140, 21'h1018F);
        m[103] = in_span(cp, 21'h10380, 21'h1039F);
        m[104] = in_span(cp, 21'h103A0, 21'h103DF);
        m[105] = in_span(cp, 21'h10450, 21'h1047F);
        m[106] = in_span(cp, 21'h10480, 21'h104AF);
        m[107] = in_span(cp, 21'h10800, 21'h1083F);
        m[108] = in_span(cp, 21'h10A00, 21'h10A5F);
        m[109] = in_span(cp, 21'h1D300, 21'h1D35F);
        m[110] = in_span(cp, 21'h12000, 21'h1247F);
        m[111] = in_span(cp, 21'h1D360, 21'h1D37F);
        m[112] = in_span(cp, 21'h1B80, 21'h1BBF);
        m[113] = in_span(cp, 21'h1C00, 21'h1C4F);
        m[114] = in_span(cp, 21'h1C50, 21'h1C7F);
        m[115] = in_span(cp, 21'hA880, 21'hA8DF);
        m[116] = in_span(cp, 21'hA900, 21'hA92F);
        m[117] = in_span(cp, 21'hA930, 21'hA95F);
        m[118] = in_span(cp, 21'hAA00, 21'hAA5F);
        m[119] = in_span(cp, 21'h10190, 21'h101CF);
        m[120] = in_span(cp, 21'h101D0, 21'h101FF);
        m[121] = in_span(cp, 21'h10280, 21'h102DF) | in_span(cp, 21'h10920, 21'h1093F);
        m[122] = in_span(cp, 21'h1F000, 21'h1F09F);
        classify = m;
    endfunction

    function automatic logic [IdxWidth-1:0] clamp_index(input logic [CpWidth-1:0] cp);
        clamp_index = (cp >= PlaneTwo) ? {IdxWidth{1'b1}} : cp[IdxWidth-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/urba_front.sv */
// Front stage: accepts code points and registers their range bit masks.
// Depends on urba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urba_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [20:0]          code_point,
    input  wire logic                 last_point,
    output logic                      fq_valid,
    input  wire logic                 fq_stall,
    output urba_pkg::class_item_t     fq_item
);
    import urba_pkg::*;

    logic        valid_reg;
    class_item_t item_reg;

    assign in_stall = valid_reg & fq_stall;
    assign fq_valid = valid_reg;
    assign fq_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.bits <= classify(code_point);
            item_reg.cp   <= code_point;
            item_reg.last <= last_point;
        end
    end
endmodule
`default_nettype wire

/* rtl/urba_queue.sv */
// Two-entry queue between classify and accumulate stages.
// Depends on urba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urba_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_stall,
    input  urba_pkg::class_item_t wr_item,
    output logic                  rd_valid,
    input  wire logic             rd_stall,
    output urba_pkg::class_item_t rd_item
);
    import urba_pkg::*;

    class_item_t mem_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid & ~wr_stall;
    assign pop      = rd_valid & ~rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_item;
    end
endmodule
`default_nettype wire

/* rtl/urba_back.sv */
// Back stage: ORs masks, tracks least and greatest point, emits on last.
// Depends on urba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urba_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output logic                  q_stall,
    input  urba_pkg::class_item_t q_item,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [31:0]           range_bits_1,
    output logic [31:0]           range_bits_2,
    output logic [31:0]           range_bits_3,
    output logic [26:0]           range_bits_4,
    output logic [15:0]           first_char_index,
    output logic [15:0]           last_char_index
);
    import urba_pkg::*;

    logic [MaskWidth-1:0] mask_reg;
    logic [CpWidth-1:0]   least_reg;
    logic [CpWidth-1:0]   great_reg;
    logic                 ovalid_reg;
    logic [MaskWidth-1:0] omask_reg;
    logic [IdxWidth-1:0]  ofirst_reg;
    logic [IdxWidth-1:0]  olast_reg;
    logic                 take;
    logic [MaskWidth-1:0] mask_next;
    logic [CpWidth-1:0]   least_next;
    logic [CpWidth-1:0]   great_next;

    // a last transaction needs the output register free
    assign q_stall = q_item.last & ovalid_reg & out_stall;
    assign take    = q_valid & ~q_stall;

    assign mask_next  = mask_reg | q_item.bits;
    assign least_next = (q_item.cp < least_reg) ? q_item.cp : least_reg;
    assign great_next = (q_item.cp > great_reg) ? q_item.cp : great_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            least_reg  <= LeastReset;
            great_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (take)
            begin
                if (q_item.last)
                begin
                    mask_reg   <= '0;
                    least_reg  <= LeastReset;
                    great_reg  <= '0;
                    ovalid_reg <= 1'b1;
                end
                else
                begin
                    mask_reg  <= mask_next;
                    least_reg <= least_next;
                    great_reg <= great_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_item.last)
        begin
            omask_reg  <= mask_next;
            ofirst_reg <= clamp_index(least_next);
            olast_reg  <= clamp_index(great_next);
        end
    end

    assign out_valid        = ovalid_reg;
    assign range_bits_1     = omask_reg[31:0];
    assign range_bits_2     = omask_reg[63:32];
    assign range_bits_3     = omask_reg[95:64];
    assign range_bits_4     = omask_reg[122:96];
    assign first_char_index = ofirst_reg;
    assign last_char_index  = olast_reg;
endmodule
`default_nettype wire

/* rtl/unicode_range_bit_accumulator_unit.sv */
// Top level of the Unicode range bit accumulator: front, queue, back.
// Depends on urba_pkg, urba_front, urba_queue, urba_back.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | code_point, last_point
//  out     | out_valid/out_stall| range_bits_1..4, first/last_char_index
//
// One code point per cycle sustained while in_stall stays low. A taken
// transaction is registered in the front stage, then written into the queue,
// then accumulated by the back stage, which raises out_valid for a last point.
// Reset clears masks and all valid flags; min starts at 0xFFFF, max at 0.
// The back stage stalls only on a last point while a result still waits; the
// queue lets the front keep taking transactions until it fills.
`timescale 1ns / 1ps
`default_nettype none
module unicode_range_bit_accumulator_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [20:0] code_point,
    input  wire logic        last_point,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      range_bits_1,
    output logic [31:0]      range_bits_2,
    output logic [31:0]      range_bits_3,
    output logic [26:0]      range_bits_4,
    output logic [15:0]      first_char_index,
    output logic [15:0]      last_char_index
);
    import urba_pkg::*;

    logic        fq_valid;
    logic        fq_stall;
    class_item_t fq_item;
    logic        q_valid;
    logic        q_stall;
    class_item_t q_item;

    urba_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_point (code_point),
        .last_point (last_point),
        .fq_valid   (fq_valid),
        .fq_stall   (fq_stall),
        .fq_item    (fq_item)
    );

    urba_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_item  (fq_item),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_item  (q_item)
    );

    urba_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_stall          (q_stall),
        .q_item           (q_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .range_bits_1     (range_bits_1),
        .range_bits_2     (range_bits_2),
        .range_bits_3     (range_bits_3),
        .range_bits_4     (range_bits_4),
        .first_char_index (first_char_index),
        .last_char_index  (last_char_index)
    );

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(range_bits_1)
                                      && $stable(range_bits_2) && $stable(range_bits_3)
                                      && $stable(range_bits_4)
                                      && $stable(first_char_index)
                                      && $stable(last_char_index)))
        else $error("stalled result changed");

    // queue never overflows: front stall only when back side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        fq_stall |-> (q_valid && q_stall) || $past(q_stall))
        else $error("queue full without back stall");

    a_first_le_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_char_index <= last_char_index
                       || first_char_index == 16'hFFFF))
        else $error("first index above last index");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for unicode_range_bit_accumulator_unit: directed and random code point sets.
// Holds its own range table, and an accumulator model inside a small scoreboard class.
// Depends on the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    typedef struct {
        logic [20:0] lo;
        logic [20:0] hi;
        int          bitpos;
    } span_rec_t;

    typedef struct {
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [26:0] w4;
        logic [15:0] first_idx;
        logic [15:0] last_idx;
    } range_summary_t;

    span_rec_t span_tbl[$];

    task automatic add_span(input int lo, input int hi, input int b);
        span_rec_t s;
        s.lo = lo[20:0];
        s.hi = hi[20:0];
        s.bitpos = b;
        span_tbl.push_back(s);
    endtask

    task automatic load_spans();
        int t[] = '{
            'h0000,'h007F,0, 'h0080,'h00FF,1, 'h0100,'h017F,2, 'h0180,'h024F,3,
            'h0250,'h02AF,4, 'h1D00,'h1DBF,4, 'h02B0,'h02FF,5, 'hA700,'hA71F,5,
            'h0300,'h036F,6, 'h1DC0,'h1DFF,6, 'h0370,'h03FF,7, 'h2C80,'h2CFF,8,
            'h0400,'h052F,9, 'h2DE0,'h2DFF,9, 'hA640,'hA69F,9, 'h0530,'h058F,10,
            'h0590,'h05FF,11, 'hA500,'hA63F,12, 'h0600,'h06FF,13, 'h0750,'h077F,13,
            'h07C0,'h07FF,14, 'h0900,'h097F,15, 'h0980,'h09FF,16, 'h0A00,'h0A7F,17,
            'h0A80,'h0AFF,18, 'h0B00,'h0B7F,19, 'h0B80,'h0BFF,20, 'h0C00,'h0C7F,21,
            'h0C80,'h0CFF,22, 'h0D00,'h0D7F,23, 'h0E00,'h0E7F,24, 'h0E80,'h0EFF,25,
            'h10A0,'h10FF,26, 'h2D00,'h2D2F,26, 'h1B00,'h1B7F,27, 'h1100,'h11FF,28,
            'h1E00,'h1EFF,29, 'h2C60,'h2C7F,29, 'hA720,'hA7FF,29, 'h1F00,'h1FFF,30,
            'h2000,'h206F,31, 'h2E00,'h2E7F,31, 'h2070,'h209F,32, 'h20A0,'h20CF,33,
            'h20D0,'h20FF,34, 'h2100,'h214F,35, 'h2150,'h218F,36, 'h2190,'h21FF,37,
            'h27F0,'h27FF,37, 'h2900,'h297F,37, 'h2B00,'h2BFF,37, 'h2200,'h22FF,38,
            'h2A00,'h2AFF,38, 'h27C0,'h27EF,38, 'h2980,'h29FF,38, 'h2300,'h23FF,39,
            'h2400,'h243F,40, 'h2440,'h245F,41, 'h2460,'h24FF,42, 'h2500,'h257F,43,
            'h2580,'h259F,44, 'h25A0,'h25FF,45, 'h2600,'h26FF,46, 'h2700,'h27BF,47,
            'h3000,'h303F,48, 'h3040,'h309F,49, 'h30A0,'h30FF,50, 'h31F0,'h31FF,50,
            'h3100,'h312F,51, 'h31A0,'h31BF,51, 'h3130,'h318F,52, 'hA840,'hA87F,53,
            'h3200,'h32FF,54, 'h3300,'h33FF,55, 'hAC00,'hD7AF,56, 'hD800,'hDFFF,57,
            'h10000,'h1FFFFF,57, 'h10900,'h1091F,58, 'h4E00,'h9FFF,59, 'h2E80,'h2EFF,59,
            'h2F00,'h2FDF,59, 'h2FF0,'h2FFF,59, 'h3400,'h4DBF,59, 'h20000,'h2F7FF,59,
            'h3190,'h319F,59, 'hE000,'hF8FF,60, 'h31C0,'h31EF,61, 'hF900,'hFAFF,61,
            'h2F800,'h2FA1F,61, 'hFB00,'hFB4F,62, 'hFB50,'hFDFF,63, 'hFE20,'hFE2F,64,
            'hFE10,'hFE1F,65, 'hFE30,'hFE4F,65, 'hFE50,'hFE6F,66, 'hFE70,'hFEFF,67,
            'hFF00,'hFFEF,68, 'hFFF0,'hFFFF,69, 'h0F00,'h0FFF,70, 'h0700,'h074F,71,
            'h0780,'h07BF,72, 'h0D80,'h0DFF,73, 'h1000,'h109F,74, 'h1200,'h139F,75,
            'h2D80,'h2DDF,75, 'h13A0,'h13FF,76, 'h1400,'h167F,77, 'h1680,'h169F,78,
            'h16A0,'h16FF,79, 'h1780,'h17FF,80, 'h19E0,'h19FF,80, 'h1800,'h18AF,81,
            'h2800,'h28FF,82, 'hA000,'hA4CF,83, 'h1700,'h177F,84, 'h10300,'h1032F,85,
            'h10330,'h1034F,86, 'h10400,'h1044F,87, 'h1D000,'h1D24F,88,
            'h1D400,'h1D7FF,89, 'hFF000,'hFFFFD,90, 'h100000,'h10FFFD,90,
            'hFE00,'hFE0F,91, 'hE0100,'hE01EF,91, 'hE0000,'hE007F,92, 'h1900,'h194F,93,
            'h1950,'h197F,94, 'h1980,'h19DF,95, 'h1A00,'h1A1F,96, 'h2C00,'h2C5F,97,
            'h2D30,'h2D7F,98, 'h4DC0,'h4DFF,99, 'hA800,'hA82F,100,
            'h10000,'h1013F,101, 'h10140,'h1018F,102, 'h10380,'h1039F,103,
            'h103A0,'h103DF,104, 'h10450,'h1047F,105, 'h10480,'h104AF,106,
            'h10800,'h1083F,107, 'h10A00,'h10A5F,108, 'h1D300,'h1D35F,109,
            'h12000,'h1247F,110, 'h1D360,'h1D37F,111, 'h1B80,'h1BBF,112,
            'h1C00,'h1C4F,113, 'h1C50,'h1C7F,114, 'hA880,'hA8DF,115, 'hA900,'hA92F,116,
            'hA930,'hA95F,117, 'hAA00,'hAA5F,118, 'h10190,'h101CF,119,
            'h101D0,'h101FF,120, 'h10280,'h102DF,121, 'h10920,'h1093F,121,
            'h1F000,'h1F09F,122};
        for (int i = 0; i < t.size(); i += 3)
            add_span(t[i], t[i+1], t[i+2]);
    endtask

    class range_scoreboard;
        logic [122:0]   acc_mask;
        logic [20:0]    least_cp;
        logic [20:0]    greatest_cp;
        range_summary_t pending[$];
        int             errors;
        int             checked;

        function new();
            errors = 0;
            checked = 0;
            clear_set();
        endfunction

        function void clear_set();
            acc_mask = '0;
            least_cp = 21'h00FFFF;
            greatest_cp = '0;
        endfunction

        function logic [15:0] clamp16(input logic [20:0] cp);
            return (cp >= 21'h010000) ? 16'hFFFF : cp[15:0];
        endfunction

        // Accumulate one code point; close the set on its last point.
        function void note_point(input logic [20:0] cp, input logic last);
            range_summary_t r;
            if (cp < least_cp) least_cp = cp;
            if (cp > greatest_cp) greatest_cp = cp;
            foreach (span_tbl[i])
                if (cp >= span_tbl[i].lo && cp <= span_tbl[i].hi)
                    acc_mask[span_tbl[i].bitpos] = 1'b1;
            if (last)
            begin
                r.w1 = acc_mask[31:0];
                r.w2 = acc_mask[63:32];
                r.w3 = acc_mask[95:64];
                r.w4 = acc_mask[122:96];
                r.first_idx = clamp16(least_cp);
                r.last_idx = clamp16(greatest_cp);
                pending.push_back(r);
                clear_set();
            end
        endfunction

        function void check_summary(input range_summary_t got);
            range_summary_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.w1 !== e.w1)
            begin
                $error("range_bits_1 exp %h got %h", e.w1, got.w1);
                errors++;
            end
            if (got.w2 !== e.w2)
            begin
                $error("range_bits_2 exp %h got %h", e.w2, got.w2);
                errors++;
            end
            if (got.w3 !== e.w3)
            begin
                $error("range_bits_3 exp %h got %h", e.w3, got.w3);
                errors++;
            end
            if (got.w4 !== e.w4)
            begin
                $error("range_bits_4 exp %h got %h", e.w4, got.w4);
                errors++;
            end
            if (got.first_idx !== e.first_idx)
            begin
                $error("first_char_index exp %h got %h", e.first_idx, got.first_idx);
                errors++;
            end
            if (got.last_idx !== e.last_idx)
            begin
                $error("last_char_index exp %h got %h", e.last_idx, got.last_idx);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [20:0] code_point;
    logic        last_point;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] range_bits_1;
    logic [31:0] range_bits_2;
    logic [31:0] range_bits_3;
    logic [26:0] range_bits_4;
    logic [15:0] first_char_index;
    logic [15:0] last_char_index;

    range_scoreboard sb;
    bit   hold_drain;
    bit   hold_done;
    int   idle_cycles;
    int   sent;

    unicode_range_bit_accumulator_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .code_point(code_point), .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .range_bits_1(range_bits_1), .range_bits_2(range_bits_2),
        .range_bits_3(range_bits_3), .range_bits_4(range_bits_4),
        .first_char_index(first_char_index), .last_char_index(last_char_index)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_point(input logic [20:0] cp, input logic last);
        int g;
        code_point <= cp;
        last_point <= last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_point(cp, last);
        sent++;
        @(negedge clk);
        g = gap_len();
        // keep valid up for a back-to-back follower
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic logic [20:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 21'($urandom_range(0, 'h2FFF));
        if (r < 50) return 21'($urandom_range('h3000, 'hFFFF));
        if (r < 65) return 21'(span_tbl[$urandom_range(0, span_tbl.size() - 1)].lo
                               + $urandom_range(0, 3));
        if (r < 75) return span_tbl[$urandom_range(0, span_tbl.size() - 1)].hi;
        if (r < 92) return 21'($urandom_range('h10000, 'h10FFFF));
        return 21'($urandom_range('h110000, 'h1FFFFF));
    endfunction

    // Receiver: random stalls, plus one long hold-off while the sender runs.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_drain)
            out_stall <= 1'b1;
        else if (idle_cycles > 0)
        begin
            idle_cycles <= idle_cycles - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            idle_cycles <= gap_len();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        wait (sent >= 300);
        hold_drain = 1'b1;
        repeat (200) @(negedge clk);
        hold_drain = 1'b0;
        hold_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            range_summary_t got;
            got.w1 = range_bits_1;
            got.w2 = range_bits_2;
            got.w3 = range_bits_3;
            got.w4 = range_bits_4;
            got.first_idx = first_char_index;
            got.last_idx = last_char_index;
            sb.check_summary(got);
        end
    end

    // Watchdog: count cycles without any accepted transaction.
    int quiet;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 2000)
        begin
            $display("FAIL unicode_range_bit_accumulator_unit");
            $finish;
        end
    end

    initial
    begin
        static logic [20:0] dir_pts[] = '{21'h0, 21'h7F, 21'h80, 21'hD800, 21'hDFFF,
                                          21'hFFFF, 21'h10000, 21'h10FFFD, 21'h110000,
                                          21'h1FFFFF, 21'hE007F, 21'h1F09F, 21'h4E00};
        int len;
        sb = new();
        quiet = 0;
        sent = 0;
        idle_cycles = 0;
        hold_drain = 1'b0;
        hold_done = 1'b0;
        in_valid = 1'b0;
        code_point = '0;
        last_point = 1'b0;
        out_stall = 1'b0;
        rst_n = 1'b0;
        load_spans();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Directed: single-point sets, one mixed set, one set beyond the basic plane.
        foreach (dir_pts[i])
            send_point(dir_pts[i], 1'b1);
        for (int i = 0; i < 6; i++)
            send_point(dir_pts[i], i == 5);
        send_point(21'h10000, 1'b0);
        send_point(21'h1FFFFF, 1'b0);
        send_point(21'h10FFFD, 1'b1);
        while (sent < 1150 || !hold_done)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_point(pick_point(), k == len - 1);
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Covered %0d code points in %0d sets, long output hold-off included.",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("PASS unicode_range_bit_accumulator_unit");
        else
            $display("FAIL unicode_range_bit_accumulator_unit");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/urba_pkg.sv
rtl/urba_front.sv
rtl/urba_queue.sv
rtl/urba_back.sv
rtl/unicode_range_bit_accumulator_unit.sv
tb/tb_top.sv
